### hdl/rmsm_pkg.sv
// Shared types, constants and width helpers for the running statistics block.
// Depends on nothing; every other file of the block imports it.
package rmsm_pkg;

    // Fixed widths of the result fields and of the internal sum of squares.
    localparam int PORT_W  = 32;
    localparam int COUNT_W = 32;
    localparam int MEAN_W  = 48;
    localparam int SDEV_W  = 48;
    localparam int M2_W    = 64;
    localparam int DIV_W   = 32;

    // Limits of the signed mean.
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIFF1,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MEAN_SIGN,
        ST_MEAN_ADD,
        ST_DIFF2,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ACCUM,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DONE
    } t_state;

    // Operations of the shared iterative unit.
    typedef enum logic [1:0] {
        OP_DIV_MEAN,
        OP_DIV_VAR,
        OP_MUL,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_iter_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Signed width that holds the scaled sample, the mean and their differences.
    function automatic int f_ext_w(input int sw, input int fb);
        return f_max(sw + fb, MEAN_W) + 2;
    endfunction

    // Magnitude width of a difference.
    function automatic int f_mag_w(input int sw, input int fb);
        return f_ext_w(sw, fb) - 1;
    endfunction

    // Numerator width of the variance division.
    function automatic int f_num_w(input int fb);
        return M2_W + fb;
    endfunction

    // Shift register width: the numerator rounded up to an even count of bits.
    function automatic int f_reg_w(input int fb);
        return f_num_w(fb) + (f_num_w(fb) % 2);
    endfunction

    function automatic int f_root_w(input int fb);
        return f_reg_w(fb) / 2;
    endfunction

    function automatic int f_acc_w(input int sw, input int fb);
        return f_max(f_max(DIV_W, f_mag_w(sw, fb)), f_root_w(fb) + 1);
    endfunction

    function automatic int f_opd_w(input int sw, input int fb);
        return f_max(f_max(DIV_W, f_mag_w(sw, fb)), f_root_w(fb));
    endfunction

    function automatic int f_add_w(input int sw, input int fb);
        return f_max(f_max(DIV_W + 1, f_mag_w(sw, fb) + 1), f_root_w(fb) + 3) + 1;
    endfunction

endpackage

### hdl/rmsm_if.sv
// Valid/ready channel interfaces for the sample input and the statistics result.
// Depends on rmsm_pkg for the field widths.
interface rmsm_sample_if;
    import rmsm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PORT_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmsm_result_if;
    import rmsm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     taken;
    logic [COUNT_W-1:0]       count;
    logic signed [PORT_W-1:0] min_seen;
    logic signed [PORT_W-1:0] max_seen;
    logic signed [MEAN_W-1:0] mean_fx;
    logic [SDEV_W-1:0]        sdev_fx;

    modport source (output valid, output taken, output count, output min_seen,
                    output max_seen, output mean_fx, output sdev_fx, input ready);
    modport sink   (input valid, input taken, input count, input min_seen,
                    input max_seen, input mean_fx, input sdev_fx, output ready);
endinterface

### hdl/rmsm_iter_unit.sv
// Shared iterative unit: restoring divide, shift-add multiply and integer square root,
// all on one add/subtract stage, one bit (two radicand bits for the root) per cycle.
// Depends on rmsm_pkg.
module rmsm_iter_unit #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  rmsm_pkg::t_iter_cmd                          i_cmd,
    input  logic [rmsm_pkg::f_reg_w(FRAC_BITS)-1:0]      i_sh_load,
    input  logic [rmsm_pkg::f_opd_w(SAMPLE_WIDTH, FRAC_BITS)-1:0] i_opd_load,
    output rmsm_pkg::t_iter_sts                          o_sts,
    output logic [rmsm_pkg::f_acc_w(SAMPLE_WIDTH, FRAC_BITS)-1:0] o_acc,
    output logic [rmsm_pkg::f_reg_w(FRAC_BITS)-1:0]      o_sh,
    output logic [rmsm_pkg::f_opd_w(SAMPLE_WIDTH, FRAC_BITS)-1:0] o_opd
);
    import rmsm_pkg::*;

    localparam int DW    = f_mag_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int NW    = f_num_w(FRAC_BITS);
    localparam int RW    = f_reg_w(FRAC_BITS);
    localparam int SQ    = f_root_w(FRAC_BITS);
    localparam int ACC_W = f_acc_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int OPD_W = f_opd_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int AW    = f_add_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int CW    = $clog2(RW + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_op              r_op, n_op;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [RW-1:0]    r_sh, n_sh;
    logic [OPD_W-1:0] r_opd, n_opd;

    logic [AW-1:0]    add_a, add_b, add_sum;
    logic             add_sub;
    logic             trial_ok;
    logic [ACC_W-1:0] st_acc;
    logic [RW-1:0]    st_sh;
    logic [OPD_W-1:0] st_opd;
    logic [CW-1:0]    start_steps;

    // Operand selection for the shared adder.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b1;
        unique case (r_op)
            OP_DIV_MEAN, OP_DIV_VAR: begin
                add_a = AW'({r_acc[DIV_W-1:0], r_sh[RW-1]});
                add_b = AW'(r_opd[DIV_W-1:0]);
            end
            OP_MUL: begin
                add_a   = AW'(r_acc[DW-1:0]);
                add_b   = r_sh[0] ? AW'(r_opd[DW-1:0]) : '0;
                add_sub = 1'b0;
            end
            OP_SQRT: begin
                add_a = AW'({r_acc[SQ:0], r_sh[RW-1 -: 2]});
                add_b = AW'({r_opd[SQ-1:0], 2'b01});
            end
        endcase
    end

    // The one adder; a clear top bit after a subtract means the trial fits.
    assign add_sum  = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
    assign trial_ok = !add_sum[AW-1];

    // Register update for one iteration of the current operation.
    always_comb begin
        st_acc = r_acc;
        st_sh  = r_sh;
        st_opd = r_opd;
        unique case (r_op)
            OP_DIV_MEAN, OP_DIV_VAR: begin
                st_acc = ACC_W'(trial_ok ? add_sum[DIV_W-1:0] : add_a[DIV_W-1:0]);
                st_sh  = {r_sh[RW-2:0], trial_ok};
            end
            OP_MUL: begin
                st_acc        = ACC_W'(add_sum[DW:1]);
                st_sh         = {1'b0, r_sh[RW-1:1]};
                st_sh[DW-1]   = add_sum[0];
            end
            OP_SQRT: begin
                st_acc = ACC_W'(trial_ok ? add_sum[SQ:0] : add_a[SQ:0]);
                st_sh  = {r_sh[RW-3:0], 2'b00};
                st_opd = {r_opd[OPD_W-2:0], trial_ok};
            end
        endcase
    end

    // Iteration count of each operation.
    always_comb begin
        unique case (i_cmd.op)
            OP_DIV_MEAN: start_steps = CW'(DW);
            OP_DIV_VAR:  start_steps = CW'(NW);
            OP_MUL:      start_steps = CW'(DW);
            OP_SQRT:     start_steps = CW'(SQ);
        endcase
    end

    // Start, step and finish control.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_opd  = r_opd;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_op   = i_cmd.op;
            n_cnt  = start_steps;
            n_acc  = '0;
            // The root works on the quotient left in the shift register.
            n_sh   = (i_cmd.op == OP_SQRT) ? r_sh : i_sh_load;
            n_opd  = (i_cmd.op == OP_SQRT) ? '0 : i_opd_load;
        end else if (r_busy) begin
            n_acc = st_acc;
            n_sh  = st_sh;
            n_opd = st_opd;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_DIV_MEAN;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_opd <= n_opd;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;
    assign o_sh       = r_sh;
    assign o_opd      = r_opd;

endmodule

### hdl/running_mean_sdev_minmax.sv
// Running count, minimum, maximum, mean and sample standard deviation of a sample stream.
// Depends on rmsm_pkg, rmsm_if and rmsm_iter_unit.
//
// Each sample beat is one of two kinds. The unknown marker (2^(SAMPLE_WIDTH-1)-1) is
// reported with taken low and leaves the statistics alone. Any other sample is counted
// and updates the count (saturating), minimum, maximum, a Welford mean and the sum of
// squared deviations, which also saturates. Mean and deviation carry FRAC_BITS
// fraction bits. The deviation is sqrt(M2/(n-1)) and reads zero until two samples
// have been counted. One result beat follows every sample beat. The input is not
// ready while a sample is being worked on. An unknown marker or a first sample needs
// no work in the shared unit. For any later sample the product is skipped when the two
// differences have opposite signs. The one shared add/subtract unit performs the
// mean division, the squared-deviation product, the variance division and the square
// root one bit per cycle each. A finished result waits in an output register. A new
// sample is taken while it waits, and only the final hand-over of the next result
// stalls on it. No clearing pass follows reset.
module running_mean_sdev_minmax #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rmsm_sample_if.sink           i_sample,
    rmsm_result_if.source         o_result
);
    import rmsm_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int EW    = f_ext_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int DW    = f_mag_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int RW    = f_reg_w(FRAC_BITS);
    localparam int SQ    = f_root_w(FRAC_BITS);
    localparam int ACC_W = f_acc_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int OPD_W = f_opd_w(SAMPLE_WIDTH, FRAC_BITS);
    localparam int INC_H = M2_W + FRAC_BITS;

    localparam logic signed [SW-1:0] UNKNOWN_CODE = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] LOWEST_CODE  = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [EW-1:0] MEAN_MAX_E   = EW'(MEAN_MAX);
    localparam logic signed [EW-1:0] MEAN_MIN_E   = EW'(MEAN_MIN);

    // Statistics.
    t_state                   r_state, n_state;
    logic [COUNT_W-1:0]       r_count, n_count;
    logic signed [SW-1:0]     r_min, n_min;
    logic signed [SW-1:0]     r_max, n_max;
    logic signed [MEAN_W-1:0] r_mean, n_mean;
    logic [M2_W-1:0]          r_m2, n_m2;
    logic [SQ-1:0]            r_sdev, n_sdev;

    // Working registers for one sample.
    logic signed [SW-1:0]     r_x, n_x;
    logic                     r_taken, n_taken;
    logic signed [EW-1:0]     r_d1, n_d1;
    logic signed [EW-1:0]     r_d2, n_d2;
    logic signed [EW-1:0]     r_q, n_q;

    // Output register.
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_taken, n_out_taken;
    logic [COUNT_W-1:0]       r_out_count, n_out_count;
    logic signed [PORT_W-1:0] r_out_min, n_out_min;
    logic signed [PORT_W-1:0] r_out_max, n_out_max;
    logic signed [MEAN_W-1:0] r_out_mean, n_out_mean;
    logic [SDEV_W-1:0]        r_out_sdev, n_out_sdev;

    // Shared unit connections.
    t_iter_cmd                iter_cmd;
    t_iter_sts                iter_sts;
    logic [RW-1:0]            sh_load;
    logic [OPD_W-1:0]         opd_load;
    logic [ACC_W-1:0]         iter_acc;
    logic [RW-1:0]            iter_sh;
    logic [OPD_W-1:0]         iter_opd;

    // Derived values.
    logic                     in_ready;
    logic                     in_accept;
    logic                     out_free;
    logic                     out_load;
    logic signed [SW-1:0]     in_x;
    logic                     is_unknown;
    logic signed [EW-1:0]     big;
    logic signed [EW-1:0]     mean_e;
    logic signed [EW-1:0]     q_e;
    logic signed [EW-1:0]     d1_abs;
    logic signed [EW-1:0]     d2_abs;
    logic                     d1_neg, d1_pos, d2_neg, d2_pos;
    logic                     opposite;
    logic [2*DW-1:0]          prod;
    logic [M2_W-1:0]          inc;
    logic [M2_W:0]            m2_sum;

    // Clamp a wide signed value into the range of the mean.
    function automatic logic signed [MEAN_W-1:0] f_clamp(input logic signed [EW-1:0] v);
        logic signed [MEAN_W-1:0] res;
        if (v > MEAN_MAX_E) begin
            res = MEAN_MAX;
        end else if (v < MEAN_MIN_E) begin
            res = MEAN_MIN;
        end else begin
            res = v[MEAN_W-1:0];
        end
        return res;
    endfunction

    rmsm_iter_unit #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (iter_cmd),
        .i_sh_load  (sh_load),
        .i_opd_load (opd_load),
        .o_sts      (iter_sts),
        .o_acc      (iter_acc),
        .o_sh       (iter_sh),
        .o_opd      (iter_opd)
    );

    // Sample decoding and arithmetic helpers.
    assign in_x       = $signed(i_sample.sample[SW-1:0]);
    assign in_accept  = in_ready && i_sample.valid;
    assign out_free   = !r_out_valid || o_result.ready;
    assign is_unknown = (r_x == UNKNOWN_CODE);
    assign big        = EW'(r_x) <<< FRAC_BITS;
    assign mean_e     = EW'(r_mean);
    assign q_e        = $signed({1'b0, iter_sh[DW-1:0]});
    assign d1_abs     = r_d1[EW-1] ? -r_d1 : r_d1;
    assign d2_abs     = r_d2[EW-1] ? -r_d2 : r_d2;
    assign d1_neg     = r_d1[EW-1];
    assign d1_pos     = !r_d1[EW-1] && (r_d1 != '0);
    assign d2_neg     = r_d2[EW-1];
    assign d2_pos     = !r_d2[EW-1] && (r_d2 != '0);
    assign opposite   = (d1_neg && d2_pos) || (d1_pos && d2_neg);

    // Scaled product and its saturated contribution to the sum of squares.
    assign prod   = {iter_acc[DW-1:0], iter_sh[DW-1:0]};
    assign inc    = (|prod[2*DW-1:INC_H]) ? '1 : prod[INC_H-1:FRAC_BITS];
    assign m2_sum = {1'b0, r_m2} + {1'b0, inc};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (in_accept) n_state = ST_CHECK;
            ST_CHECK: begin
                if (is_unknown || (r_count == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIFF1;
                end
            end
            ST_DIFF1:     n_state = ST_DIV1_GO;
            ST_DIV1_GO:   n_state = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (iter_sts.done) n_state = ST_MEAN_SIGN;
            ST_MEAN_SIGN: n_state = ST_MEAN_ADD;
            ST_MEAN_ADD:  n_state = ST_DIFF2;
            ST_DIFF2:     n_state = ST_MUL_GO;
            ST_MUL_GO:    n_state = opposite ? ST_DIV2_GO : ST_MUL_WAIT;
            ST_MUL_WAIT:  if (iter_sts.done) n_state = ST_ACCUM;
            ST_ACCUM:     n_state = ST_DIV2_GO;
            ST_DIV2_GO:   n_state = ST_DIV2_WAIT;
            ST_DIV2_WAIT: if (iter_sts.done) n_state = ST_SQRT_GO;
            ST_SQRT_GO:   n_state = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (iter_sts.done) n_state = ST_DONE;
            ST_DONE:      if (out_free) n_state = ST_IDLE;
        endcase
    end

    // Handshake and shared unit commands.
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        iter_cmd = '{start: 1'b0, op: OP_DIV_MEAN};
        sh_load  = '0;
        opd_load = '0;
        unique case (r_state)
            ST_IDLE: in_ready = !iter_sts.busy;
            ST_DIV1_GO: begin
                iter_cmd = '{start: 1'b1, op: OP_DIV_MEAN};
                sh_load  = RW'(d1_abs[DW-1:0]) << (RW - DW);
                opd_load = OPD_W'(r_count);
            end
            ST_MUL_GO: begin
                // A product of opposite signs contributes nothing.
                iter_cmd = '{start: !opposite, op: OP_MUL};
                sh_load  = RW'(d1_abs[DW-1:0]);
                opd_load = OPD_W'(d2_abs[DW-1:0]);
            end
            ST_DIV2_GO: begin
                iter_cmd = '{start: 1'b1, op: OP_DIV_VAR};
                sh_load  = {r_m2, {(RW-M2_W){1'b0}}};
                opd_load = OPD_W'(r_count - COUNT_W'(1));
            end
            ST_SQRT_GO: iter_cmd = '{start: 1'b1, op: OP_SQRT};
            ST_DONE:    out_load = out_free;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_mean      = r_mean;
        n_m2        = r_m2;
        n_sdev      = r_sdev;
        n_x         = r_x;
        n_taken     = r_taken;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_q         = r_q;
        n_out_taken = r_out_taken;
        n_out_count = r_out_count;
        n_out_min   = r_out_min;
        n_out_max   = r_out_max;
        n_out_mean  = r_out_mean;
        n_out_sdev  = r_out_sdev;
        unique case (r_state)
            ST_IDLE: if (in_accept) n_x = in_x;
            ST_CHECK: begin
                n_taken = !is_unknown;
                if (!is_unknown) begin
                    n_count = (r_count == '1) ? r_count : r_count + COUNT_W'(1);
                    if (r_x < r_min) n_min = r_x;
                    if (r_x > r_max) n_max = r_x;
                    // The first sample sets the mean outright.
                    if (r_count == '0) begin
                        n_mean = f_clamp(big);
                        n_m2   = '0;
                    end
                end
            end
            ST_DIFF1:     n_d1 = big - mean_e;
            ST_MEAN_SIGN: n_q = d1_neg ? -q_e : q_e;
            ST_MEAN_ADD:  n_mean = f_clamp(mean_e + r_q);
            ST_DIFF2:     n_d2 = big - mean_e;
            ST_ACCUM:     n_m2 = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
            ST_SQRT_WAIT: if (iter_sts.done) n_sdev = iter_opd[SQ-1:0];
            ST_DONE: begin
                if (out_load) begin
                    n_out_taken = r_taken;
                    n_out_count = r_count;
                    n_out_min   = PORT_W'(r_min);
                    n_out_max   = PORT_W'(r_max);
                    n_out_mean  = r_mean;
                    n_out_sdev  = SDEV_W'(r_sdev);
                end
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    // The output beat stays until it is taken.
    assign n_out_valid = out_load ? 1'b1 : (o_result.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_min       <= UNKNOWN_CODE;
            r_max       <= LOWEST_CODE;
            r_mean      <= '0;
            r_m2        <= '0;
            r_sdev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_mean      <= n_mean;
            r_m2        <= n_m2;
            r_sdev      <= n_sdev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_taken     <= n_taken;
        r_d1        <= n_d1;
        r_d2        <= n_d2;
        r_q         <= n_q;
        r_out_taken <= n_out_taken;
        r_out_count <= n_out_count;
        r_out_min   <= n_out_min;
        r_out_max   <= n_out_max;
        r_out_mean  <= n_out_mean;
        r_out_sdev  <= n_out_sdev;
    end

    // Channel outputs.
    assign i_sample.ready    = in_ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.taken    = r_out_taken;
    assign o_result.count    = r_out_count;
    assign o_result.min_seen = r_out_min;
    assign o_result.max_seen = r_out_max;
    assign o_result.mean_fx  = r_out_mean;
    assign o_result.sdev_fx  = r_out_sdev;

endmodule
